>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");

`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: label");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEVER(label, clk, rst, cond)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/nal_pkg.sv
// Types and constants of the netlink attribute locator.
`default_nettype none

package nal_pkg;

  localparam logic [15:0] HEADER_BYTES = 16'd16;
  localparam logic [8:0]  ALIGN_MASK   = 9'd3;

  localparam logic [1:0] PHASE_SEARCH = 2'd0;
  localparam logic [1:0] PHASE_VALUE  = 2'd1;
  localparam logic [1:0] PHASE_FOUND  = 2'd2;
  localparam logic [1:0] PHASE_BAD    = 2'd3;

  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;

  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] CFG_WANTED_TYPE = 2'd0;
  localparam logic [1:0] CFG_BODY_LENGTH = 2'd1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  value_byte;
    logic [1:0]  status;
    logic [15:0] value_length;
    logic        run_end;
  } result_t;

  // up to two results made by one accepted byte; val1 implies val0
  typedef struct packed {
    logic    val0;
    logic    val1;
    result_t item0;
    result_t item1;
  } push_t;

endpackage

`default_nettype wire

>>> rtl/netlink_attribute_locator_top.sv
// Top level of the netlink attribute locator.
// A result item is written into the queue when the byte that causes it is taken.
// Throughput: one message byte per cycle while in_stall is low; the final byte of a
// message that also carries a value byte yields two result items, drained one per
// cycle while out_stall is low from a four-entry queue, and in_stall rises while the queue holds more than two.
// Reset (rst, synchronous): walk state and queue cleared, wanted_type 0, body_length 16.
`default_nettype none

module netlink_attribute_locator_top #(
  parameter int MAX_MESSAGE_BYTES = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  message_byte,
  input  wire logic        final_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             result_kind,
  output logic [7:0]       value_byte,
  output logic [1:0]       status_code,
  output logic [15:0]      value_length,
  output logic             run_end,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import nal_pkg::*;

  push_t   push;
  result_t head;
  logic    room;
  logic    in_fire;

  assign in_stall = !room;
  assign in_fire  = in_valid && room;

  nal_walk #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_walk (
    .clk          (clk),
    .rst          (rst),
    .in_fire      (in_fire),
    .message_byte (message_byte),
    .final_byte   (final_byte),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push)
  );

  nal_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign result_kind  = head.kind;
  assign value_byte   = head.value_byte;
  assign status_code  = head.status;
  assign value_length = head.value_length;
  assign run_end      = head.run_end;

endmodule

`default_nettype wire

>>> rtl/nal_walk.sv
// Per-byte message walker: length capture, attribute header parse, value pass-through.
`default_nettype none

`include "assert_macros.svh"

module nal_walk #(
  parameter int MAX_MESSAGE_BYTES = 65535
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_fire,
  input  wire logic [7:0]   message_byte,
  input  wire logic         final_byte,
  input  wire logic         cfg_write,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data,
  output nal_pkg::push_t    push
);
  import nal_pkg::*;

  logic [15:0] wanted_type;
  logic [7:0]  body_length;

  logic [15:0] byte_position, byte_position_next;
  logic [31:0] message_total, message_total_next;
  logic [15:0] next_attribute_at, next_attribute_at_next;
  logic [23:0] attribute_header, attribute_header_next;
  logic [15:0] value_bytes_left, value_bytes_left_next;
  logic [1:0]  walk_phase, walk_phase_next;
  logic [15:0] found_length, found_length_next;

  logic [8:0]  body_aligned;
  logic        in_header;
  logic [1:0]  hdr_k;
  logic [15:0] attr_len;
  logic [15:0] attr_type;
  logic [16:0] attr_end;
  logic [16:0] len_aligned;
  logic [17:0] skip_to;
  logic        emit_value;
  result_t     value_item;
  result_t     status_item;

  assign body_aligned = ({1'b0, body_length} + ALIGN_MASK) & ~ALIGN_MASK;
  assign in_header    = (byte_position >= next_attribute_at) &&
                        ({1'b0, byte_position} < ({1'b0, next_attribute_at} + 17'd4));
  assign hdr_k        = byte_position[1:0] - next_attribute_at[1:0];
  assign attr_len     = attribute_header[15:0];
  assign attr_type    = {message_byte, attribute_header[23:16]};
  assign attr_end     = {1'b0, next_attribute_at} + {1'b0, attr_len};
  assign len_aligned  = ({1'b0, attr_len} + {8'd0, ALIGN_MASK}) & ~{8'd0, ALIGN_MASK};
  assign skip_to      = {2'b00, next_attribute_at} + {1'b0, len_aligned};

  always_comb begin
    byte_position_next     = byte_position;
    message_total_next     = message_total;
    next_attribute_at_next = next_attribute_at;
    attribute_header_next  = attribute_header;
    value_bytes_left_next  = value_bytes_left;
    walk_phase_next        = walk_phase;
    found_length_next      = found_length;
    emit_value             = 1'b0;

    if (byte_position != 16'hFFFF) begin
      byte_position_next = byte_position + 16'd1;
    end

    if (byte_position < 16'd4) begin
      case (byte_position[1:0])
        2'd0: message_total_next[7:0]   = message_byte;
        2'd1: message_total_next[15:8]  = message_byte;
        2'd2: message_total_next[23:16] = message_byte;
        default: begin
          message_total_next[31:24] = message_byte;
          next_attribute_at_next = HEADER_BYTES + {7'd0, body_aligned};
          if (message_total_next > 32'(MAX_MESSAGE_BYTES)) begin
            walk_phase_next = PHASE_BAD;
          end
        end
      endcase
    end else if ({16'd0, byte_position} < message_total) begin
      if (walk_phase == PHASE_SEARCH) begin
        if (in_header) begin
          case (hdr_k)
            2'd0: attribute_header_next[7:0]   = message_byte;
            2'd1: attribute_header_next[15:8]  = message_byte;
            2'd2: attribute_header_next[23:16] = message_byte;
            default: begin
              if (attr_len < 16'd4 || {15'd0, attr_end} > message_total) begin
                walk_phase_next = PHASE_BAD;
              end else if (attr_type == wanted_type) begin
                found_length_next     = attr_len - 16'd4;
                value_bytes_left_next = attr_len - 16'd4;
                walk_phase_next = (attr_len == 16'd4) ? PHASE_FOUND : PHASE_VALUE;
              end else begin
                next_attribute_at_next = (skip_to > 18'h0FFFF) ? 16'hFFFF : skip_to[15:0];
              end
            end
          endcase
        end
      end else if (walk_phase == PHASE_VALUE) begin
        emit_value            = 1'b1;
        value_bytes_left_next = value_bytes_left - 16'd1;
        if (value_bytes_left == 16'd1) begin
          walk_phase_next = PHASE_FOUND;
        end
      end
    end

    value_item.kind         = KIND_VALUE;
    value_item.value_byte   = message_byte;
    value_item.status       = ST_FOUND;
    value_item.value_length = 16'd0;
    value_item.run_end      = 1'b0;

    status_item.kind         = KIND_STATUS;
    status_item.value_byte   = 8'd0;
    status_item.value_length = 16'd0;
    status_item.run_end      = 1'b1;
    if (byte_position_next < 16'd4 || walk_phase_next == PHASE_BAD ||
        {16'd0, byte_position_next} < message_total_next) begin
      status_item.status = ST_MALFORMED;
    end else if (walk_phase_next == PHASE_FOUND) begin
      status_item.status       = ST_FOUND;
      status_item.value_length = found_length_next;
    end else begin
      status_item.status = ST_NOT_FOUND;
    end

    // end of message: back to the start state, registers kept
    if (final_byte) begin
      byte_position_next     = 16'd0;
      message_total_next     = 32'd0;
      next_attribute_at_next = 16'd0;
      attribute_header_next  = 24'd0;
      value_bytes_left_next  = 16'd0;
      walk_phase_next        = PHASE_SEARCH;
      found_length_next      = 16'd0;
    end

    push.val0  = in_fire && (emit_value || final_byte);
    push.val1  = in_fire && emit_value && final_byte;
    push.item0 = emit_value ? value_item : status_item;
    push.item1 = status_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_type       <= 16'd0;
      body_length       <= 8'd16;
      byte_position     <= 16'd0;
      message_total     <= 32'd0;
      next_attribute_at <= 16'd0;
      attribute_header  <= 24'd0;
      value_bytes_left  <= 16'd0;
      walk_phase        <= PHASE_SEARCH;
      found_length      <= 16'd0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_WANTED_TYPE: wanted_type <= cfg_data;
          CFG_BODY_LENGTH: body_length <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        byte_position     <= byte_position_next;
        message_total     <= message_total_next;
        next_attribute_at <= next_attribute_at_next;
        attribute_header  <= attribute_header_next;
        value_bytes_left  <= value_bytes_left_next;
        walk_phase        <= walk_phase_next;
        found_length      <= found_length_next;
      end
    end
  end

  `ASSERT_IMPLIES(a_value_left_nonzero, clk, rst, walk_phase == PHASE_VALUE,
                  value_bytes_left != 16'd0)
  `ASSERT_IMPLIES(a_second_is_status, clk, rst, push.val1,
                  push.val0 && push.item1.run_end && push.item0.kind == KIND_VALUE)
  `ASSERT_IMPLIES(a_value_only_in_value_phase, clk, rst,
                  push.val0 && push.item0.kind == KIND_VALUE, walk_phase == PHASE_VALUE)

endmodule

`default_nettype wire

>>> rtl/nal_outq.sv
// Four-entry result queue: takes up to two results a cycle, sends one unless out_stall is high.
`default_nettype none

`include "assert_macros.svh"

module nal_outq (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire nal_pkg::push_t push,
  output logic             room,
  output logic             out_valid,
  input  wire logic        out_stall,
  output nal_pkg::result_t head
);
  import nal_pkg::*;

  result_t    entries [4];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;
  logic [2:0] count_next;
  logic       pop;

  assign room      = (count <= 3'd2);
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign head      = entries[rptr];

  always_comb begin
    count_next = count + {2'd0, push.val0} + {2'd0, push.val1} - {2'd0, pop};
  end

  always_ff @(posedge clk) begin
    if (push.val0) begin
      entries[wptr] <= push.item0;
    end
    if (push.val1) begin
      entries[wptr + 2'd1] <= push.item1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 2'd0;
      rptr  <= 2'd0;
      count <= 3'd0;
    end else begin
      wptr  <= wptr + {1'b0, push.val0} + {1'b0, push.val1};
      rptr  <= rptr + {1'b0, pop};
      count <= count_next;
    end
  end

  `ASSERT_NEVER(a_count_bound, clk, rst, count > 3'd4)
  `ASSERT_IMPLIES(a_push_has_room, clk, rst, push.val0, count <= 3'd2)
  `ASSERT_NEXT(a_pop_drains, clk, rst, pop && !push.val0, count == $past(count) - 3'd1)

endmodule

`default_nettype wire

>>> tb/sv/netlink_attribute_locator_top_test.sv
// Testbench for the netlink attribute locator: message stimulus, model and result check.
module netlink_attribute_locator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nal_pkg::*;

  localparam int MAX_BYTES = 65535;
  localparam int ATTR_HEADER_BYTES = 4;
  localparam int ITEM_TARGET = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TIMEOUT_NS = 5_000_000;

  // indexes past the register list; writes to them must change nothing
  localparam logic [1:0] CFG_UNMAPPED_0 = 2'd2;
  localparam logic [1:0] CFG_UNMAPPED_1 = 2'd3;

  // Mirror of the attribute walk; queues the value bytes and statuses each byte causes.
  class locator_mirror;
    logic [15:0] wanted_type;
    logic [7:0] body_length;
    int unsigned byte_count;
    int unsigned msg_length;
    int unsigned attr_at;
    int unsigned attr_word;
    int unsigned value_left;
    int unsigned match_length;
    logic [1:0] phase;
    result_t outputs_due[$];
    int mismatches;

    function new();
      wanted_type = '0;
      body_length = 8'd16;
      mismatches = 0;
      clear_walk();
    endfunction

    function void clear_walk();
      byte_count = 0;
      msg_length = 0;
      attr_at = 0;
      attr_word = 0;
      value_left = 0;
      match_length = 0;
      phase = PHASE_SEARCH;
    endfunction

    function int unsigned round_up4(int unsigned v);
      return (v + 32'(ALIGN_MASK)) & ~32'(ALIGN_MASK);
    endfunction

    function void set_register(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_WANTED_TYPE: wanted_type = data;
        CFG_BODY_LENGTH: body_length = data[7:0];
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      int unsigned p;
      int unsigned k;
      int unsigned alen;
      int unsigned atype;
      int unsigned nx;
      result_t r;
      p = byte_count;
      if (byte_count < 32'hFFFF) byte_count++;
      if (p < 4) begin
        msg_length |= 32'(b) << (8 * p);
        if (p == 3) begin
          attr_at = 32'(HEADER_BYTES) + round_up4(32'(body_length));
          if (msg_length > MAX_BYTES) phase = PHASE_BAD;
        end
      end else if (p < msg_length) begin
        if (phase == PHASE_SEARCH) begin
          if (p >= attr_at && p < attr_at + ATTR_HEADER_BYTES) begin
            k = p - attr_at;
            if (k == 0) attr_word = 0;
            attr_word |= 32'(b) << (8 * k);
            if (k == 3) begin
              alen = attr_word & 32'hFFFF;
              atype = attr_word >> 16;
              if (alen < ATTR_HEADER_BYTES || attr_at + alen > msg_length) begin
                phase = PHASE_BAD;
              end else if (atype == 32'(wanted_type)) begin
                match_length = alen - ATTR_HEADER_BYTES;
                value_left = match_length;
                phase = (value_left == 0) ? PHASE_FOUND : PHASE_VALUE;
              end else begin
                nx = attr_at + round_up4(alen);
                attr_at = (nx > 32'hFFFF) ? 32'hFFFF : nx;
              end
            end
          end
        end else if (phase == PHASE_VALUE) begin
          r.kind = KIND_VALUE;
          r.value_byte = b;
          r.status = '0;
          r.value_length = '0;
          r.run_end = 1'b0;
          outputs_due.push_back(r);
          value_left--;
          if (value_left == 0) phase = PHASE_FOUND;
        end
      end
      if (last) begin
        r.kind = KIND_STATUS;
        r.value_byte = '0;
        r.value_length = '0;
        r.run_end = 1'b1;
        if (byte_count < 4 || phase == PHASE_BAD || byte_count < msg_length) begin
          r.status = ST_MALFORMED;
        end else if (phase == PHASE_FOUND) begin
          r.status = ST_FOUND;
          r.value_length = match_length[15:0];
        end else begin
          r.status = ST_NOT_FOUND;
        end
        outputs_due.push_back(r);
        clear_walk();
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_output(result_t got);
      result_t want;
      if (outputs_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected: kind %0h byte %0h status %0h len %0h end %0h",
                 $time, got.kind, got.value_byte, got.status, got.value_length, got.run_end);
        return;
      end
      want = outputs_due.pop_front();
      compare_field("result_kind", 16'(want.kind), 16'(got.kind));
      compare_field("value_byte", 16'(want.value_byte), 16'(got.value_byte));
      compare_field("status_code", 16'(want.status), 16'(got.status));
      compare_field("value_length", want.value_length, got.value_length);
      compare_field("run_end", 16'(want.run_end), 16'(got.run_end));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] message_byte = '0;
  logic final_byte = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic result_kind;
  logic [7:0] value_byte;
  logic [1:0] status_code;
  logic [15:0] value_length;
  logic run_end;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  locator_mirror board;
  logic [7:0] frame[$];
  bit steady = 1'b0;
  int bytes_sent = 0;

  netlink_attribute_locator_top #(
    .MAX_MESSAGE_BYTES(MAX_BYTES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .message_byte(message_byte),
    .final_byte(final_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_kind(result_kind),
    .value_byte(value_byte),
    .status_code(status_code),
    .value_length(value_length),
    .run_end(run_end),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_output({result_kind, value_byte, status_code, value_length, run_end});
    end
  end

  // receiver: random stall before each result item, none while steady
  initial begin
    int hold;
    wait (!rst);
    forever begin
      @(negedge clk);
      hold = steady ? 0 : $urandom_range(0, 6);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // message assembly helpers; all little-endian
  function automatic void put16(int unsigned v);
    frame.push_back(8'(v));
    frame.push_back(8'(v >> 8));
  endfunction

  function automatic void set_total(logic [31:0] v);
    frame[0] = v[7:0];
    frame[1] = v[15:8];
    frame[2] = v[23:16];
    frame[3] = v[31:24];
  endfunction

  function automatic void start_frame();
    frame.delete();
    repeat (4) frame.push_back(8'h00);
    repeat (12) frame.push_back(8'($urandom));
    repeat (board.round_up4(32'(board.body_length))) frame.push_back(8'($urandom));
  endfunction

  function automatic void add_attr(int unsigned len, int unsigned typ, int unsigned nvalue);
    put16(len);
    put16(typ);
    repeat (nvalue) frame.push_back(8'($urandom));
  endfunction

  function automatic void pad_frame();
    while (frame.size() % 4 != 0) frame.push_back(8'($urandom));
  endfunction

  function automatic void seal_frame();
    set_total(32'(frame.size()));
  endfunction

  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (board.outputs_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
    drain_outputs();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    board.set_register(idx, data);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    message_byte <= b;
    final_byte <= last;
    do @(posedge clk); while (in_stall);
    board.take_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  // sends the first count bytes of the frame, final on the last one
  task automatic send_frame(input int count);
    int pause_at;
    pause_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, count - 1) : -1;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain_outputs();
      send_byte(frame[i], i == count - 1);
    end
  endtask

  initial begin
    int unsigned random_start;
    int unsigned n_attr;
    int unsigned k;
    int unsigned len;
    int unsigned typ;
    int deliver;
    int n;
    logic [1:0] idx;
    logic [15:0] data;

    board = new();
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // short input: a single byte
    frame = '{8'h00};
    send_frame(1);
    // length of exactly four, nothing to walk
    frame = '{8'h04, 8'h00, 8'h00, 8'h00};
    send_frame(4);
    // zero length; the rest is trailing
    frame = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h55};
    send_frame(6);
    // over capacity, widest and just past the limit
    frame = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h12, 8'h34};
    send_frame(6);
    frame = '{8'h00, 8'h00, 8'h01, 8'h00, 8'hAB};
    send_frame(5);
    // skip with rounding, then a match whose value ends the message
    start_frame();
    add_attr(5, 16'h0001, 1);
    pad_frame();
    add_attr(8, 16'h0000, 4);
    seal_frame();
    send_frame(frame.size());

    write_register(CFG_WANTED_TYPE, 16'hFFFF);
    write_register(CFG_BODY_LENGTH, {8'h5A, 8'd255});
    // zero-length match; the later duplicate must not win
    start_frame();
    add_attr(8, 16'h0000, 4);
    add_attr(4, 16'hFFFF, 0);
    add_attr(8, 16'hFFFF, 4);
    seal_frame();
    send_frame(frame.size());

    write_register(CFG_BODY_LENGTH, {8'hC3, 8'd0});
    // attribute lengths below the header size
    start_frame();
    add_attr(3, 16'hFFFF, 0);
    seal_frame();
    send_frame(frame.size());
    start_frame();
    add_attr(0, 16'h0000, 0);
    seal_frame();
    send_frame(frame.size());
    // attribute running past the message
    start_frame();
    add_attr(100, 16'h0007, 4);
    seal_frame();
    send_frame(frame.size());
    // next header straddles the end of the message
    start_frame();
    add_attr(8, 16'h0002, 4);
    frame.push_back(8'($urandom));
    frame.push_back(8'($urandom));
    seal_frame();
    send_frame(frame.size());
    // long value, length field uses both bytes
    start_frame();
    add_attr(264, 16'hFFFF, 260);
    seal_frame();
    send_frame(frame.size());
    // input stops in the middle of a value
    start_frame();
    add_attr(16, 16'hFFFF, 12);
    seal_frame();
    send_frame(frame.size() - 9);
    // input stops while still searching
    start_frame();
    add_attr(8, 16'h0003, 4);
    add_attr(8, 16'h0004, 4);
    seal_frame();
    send_frame(frame.size() - 5);

    write_register(CFG_UNMAPPED_0, 16'($urandom));
    write_register(CFG_UNMAPPED_1, 16'($urandom));
    start_frame();
    add_attr(7, 16'hFFFF, 3);
    pad_frame();
    seal_frame();
    send_frame(frame.size());

    // largest message; the skip target saturates and ends the walk
    steady = 1'b1;
    start_frame();
    add_attr(65519, 16'h1234, 65515);
    set_total(32'd65535);
    frame.push_back(8'h77);
    frame.push_back(8'h88);
    send_frame(frame.size());
    steady = 1'b0;

    random_start = bytes_sent;
    while (bytes_sent - random_start < ITEM_TARGET) begin
      if ($urandom_range(0, 5) == 0) begin
        idx = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
          0: data = 16'h0000;
          1: data = 16'hFFFF;
          default: data = 16'($urandom);
        endcase
        if (idx == CFG_BODY_LENGTH) begin
          case ($urandom_range(0, 7))
            0: data[7:0] = 8'd255;
            1: data[7:0] = 8'd0;
            default: data[7:0] = 8'($urandom_range(0, 20));
          endcase
        end
        write_register(idx, data);
      end
      steady = ($urandom_range(0, 3) == 0);

      start_frame();
      n_attr = $urandom_range(0, 4);
      for (k = 0; k < n_attr; k++) begin
        typ = ($urandom_range(0, 2) == 0) ? 32'(board.wanted_type) : $urandom_range(0, 65535);
        len = ATTR_HEADER_BYTES + (($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12));
        add_attr(len, typ, len - ATTR_HEADER_BYTES);
        pad_frame();
      end
      seal_frame();
      deliver = frame.size();
      case ($urandom_range(0, 9))
        0: deliver = $urandom_range(1, frame.size() - 1);
        1: begin
          // broken attribute at the end of the walk
          len = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(5, 400);
          add_attr(len, $urandom_range(0, 65535), 0);
          seal_frame();
          deliver = frame.size();
        end
        2: set_total($urandom_range(0, 1) ? $urandom : $urandom_range(0, frame.size() + 8));
        3: begin
          repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom));
          seal_frame();
          deliver = frame.size();
        end
        4: begin
          frame.delete();
          repeat ($urandom_range(1, 12)) frame.push_back(8'($urandom));
          deliver = frame.size();
        end
        5, 6: begin
          repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom));
          deliver = frame.size();
        end
        default: ;
      endcase
      send_frame(deliver);
    end

    steady = 1'b0;
    in_valid <= 1'b0;
    n = 0;
    while (board.outputs_due.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (board.outputs_due.size() != 0) begin
      board.mismatches++;
      $display("%0t: %0d expected results never arrived", $time, board.outputs_due.size());
    end
    if (board.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/nal_pkg.sv
rtl/nal_walk.sv
rtl/nal_outq.sv
rtl/netlink_attribute_locator_top.sv
tb/sv/netlink_attribute_locator_top_test.sv
